// ===== rtl/core/jaam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaam_pkg
// Shared types and constants for the joystick axis auto-calibration mapper.
// ----------------------------------------------------------------------------
package jaam_pkg;

  // Full-scale magnitude of a mapped axis value
  localparam int FULL_SCALE = 32760;

  // Quotient bits produced by the lane divider (quotient never exceeds FULL_SCALE)
  localparam int QUO_BITS = 15;

  // Width of a mapped axis value on the output
  localparam int AXIS_W = 16;

  // Reset rest position of both axes
  localparam int CENTER_RESET = 2048;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_CENTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y = 2'd3;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_PREP,
    LANE_DIV,
    LANE_FIN
  } lane_state_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_BUSY,
    CTL_PEND
  } ctl_state_t;

  // Status a lane reports to the controller and the merging stage
  typedef struct packed {
    logic done;   // mapped value written this cycle
    logic moved;  // the last sample widened a bound
  } lane_stat_t;

endpackage

// ===== rtl/core/jaam_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaam_lane
// One axis: bound tracking, piecewise scaling and a bit-per-cycle divider.
// ----------------------------------------------------------------------------
module jaam_lane #(
  parameter int ADC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [ADC_BITS-1:0]                   sample,
  input  logic [ADC_BITS-1:0]                   center,
  input  logic                                  invert,
  output logic signed [jaam_pkg::AXIS_W-1:0]    axis,
  output logic [ADC_BITS-1:0]                   lo,
  output logic [ADC_BITS-1:0]                   hi,
  output jaam_pkg::lane_stat_t                  stat
);

  localparam int NUM_W = ADC_BITS + jaam_pkg::QUO_BITS;
  localparam int CNT_W = $clog2(jaam_pkg::QUO_BITS);
  localparam int MAP_W = jaam_pkg::QUO_BITS + 2;

  jaam_pkg::lane_state_t state, state_next;

  logic                          prep_en;
  logic                          step_en;
  logic                          fin_en;

  logic [ADC_BITS-1:0]           sample_r;
  logic                          moved;
  logic                          below;
  logic                          den_zero;
  logic [NUM_W-1:0]              rem;
  logic [NUM_W-1:0]              dvs;
  logic [jaam_pkg::QUO_BITS-1:0] quo;
  logic [CNT_W-1:0]              cnt;

  logic [ADC_BITS-1:0]           lo_next;
  logic [ADC_BITS-1:0]           hi_next;
  logic                          below_calc;
  logic [ADC_BITS-1:0]           diff;
  logic [ADC_BITS-1:0]           den_calc;
  logic [NUM_W-1:0]              num_calc;
  logic                          geq;
  logic signed [MAP_W-1:0]       mapped;
  logic signed [MAP_W-1:0]       result;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      jaam_pkg::LANE_IDLE: if (start) state_next = jaam_pkg::LANE_PREP;
      jaam_pkg::LANE_PREP: state_next = jaam_pkg::LANE_DIV;
      jaam_pkg::LANE_DIV:  if (cnt == '0) state_next = jaam_pkg::LANE_FIN;
      jaam_pkg::LANE_FIN:  state_next = jaam_pkg::LANE_IDLE;
      default:             state_next = jaam_pkg::LANE_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    prep_en    = (state == jaam_pkg::LANE_PREP);
    step_en    = (state == jaam_pkg::LANE_DIV);
    fin_en     = (state == jaam_pkg::LANE_FIN);
    stat.done  = fin_en;
    stat.moved = moved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jaam_pkg::LANE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Widen bounds with the incoming sample
  always_comb begin
    lo_next = (sample < lo) ? sample : lo;
    hi_next = (sample > hi) ? sample : hi;
  end

  // Operands of the scaling division
  always_comb begin
    below_calc = (sample_r < center);
    diff       = below_calc ? (sample_r - lo) : (sample_r - center);
    den_calc   = below_calc ? (center - lo) : (hi - center);
    num_calc   = NUM_W'(diff) * NUM_W'(jaam_pkg::FULL_SCALE);
    geq        = (rem >= dvs);
  end

  // Offset the lower half, zero on an empty upper range, then invert
  always_comb begin
    if (below) begin
      mapped = $signed({2'b00, quo}) - $signed(MAP_W'(jaam_pkg::FULL_SCALE));
    end else if (den_zero) begin
      mapped = '0;
    end else begin
      mapped = $signed({2'b00, quo});
    end
    result = invert ? -mapped : mapped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (start && (state == jaam_pkg::LANE_IDLE)) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == jaam_pkg::LANE_IDLE)) begin
      sample_r <= sample;
      moved    <= (sample < lo) || (sample > hi);
    end
    if (prep_en) begin
      below    <= below_calc;
      den_zero <= (den_calc == '0);
      rem      <= num_calc;
      dvs      <= NUM_W'(den_calc) << (jaam_pkg::QUO_BITS - 1);
      quo      <= '0;
      cnt      <= CNT_W'(jaam_pkg::QUO_BITS - 1);
    end
    if (step_en) begin
      if (geq) rem <= rem - dvs;
      dvs <= dvs >> 1;
      quo <= {quo[jaam_pkg::QUO_BITS-2:0], geq};
      cnt <= cnt - 1'b1;
    end
    if (fin_en) begin
      axis <= result[jaam_pkg::AXIS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/jaam_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaam_merge
// Combine both lanes into one result and hold it in the output register.
// ----------------------------------------------------------------------------
module jaam_merge #(
  parameter int ADC_BITS = 12,
  parameter int OUT_W    = 88
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [jaam_pkg::AXIS_W-1:0]   x_axis,
  input  logic signed [jaam_pkg::AXIS_W-1:0]   y_axis,
  input  logic [ADC_BITS-1:0]                  x_lo,
  input  logic [ADC_BITS-1:0]                  x_hi,
  input  logic [ADC_BITS-1:0]                  y_lo,
  input  logic [ADC_BITS-1:0]                  y_hi,
  input  jaam_pkg::lane_stat_t                 x_stat,
  input  jaam_pkg::lane_stat_t                 y_stat,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [OUT_W-1:0]                     m_tdata
);

  logic signed [jaam_pkg::AXIS_W-1:0] last_x;
  logic signed [jaam_pkg::AXIS_W-1:0] last_y;
  logic                               axes_changed;
  logic                               bounds_changed;

  always_comb begin
    axes_changed   = (x_axis != last_x) || (y_axis != last_y);
    bounds_changed = x_stat.moved || y_stat.moved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      last_x   <= '0;
      last_y   <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      last_x   <= x_axis;
      last_y   <= y_axis;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_W'({bounds_changed, y_hi, y_lo, x_hi, x_lo,
                         axes_changed, y_axis, x_axis});
    end
  end

endmodule

// ===== rtl/core/joystick_axis_autocal_mapper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_autocal_mapper_unit
// Two-axis joystick mapper with self-widening calibration bounds.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw ADC sample per axis. The block widens
// the tracked low/high bounds of each axis, then scales the sample about the
// configured centre onto -32760..-1 below it and 0..32760 from it upwards,
// rounding down (an empty upper range maps to 0), and negates the
// value if the axis invert bit is set. The x and y axes run in two identical
// lanes side by side; a merging stage compares the pair against the previous
// result, collects the bounds and loads the output register. One item is
// worked on at a time: the input transaction is followed by the operand
// setup, the 15 steps of the restoring divider in each lane (one quotient
// bit per cycle), the final offset/invert and the output load, which waits
// while the output register holds an untaken result. s_tready rises again
// together with the result, even if that result has not yet been taken, so
// the next sample overlaps the wait for the consumer. Configuration writes
// take effect at once and should be made only while no item is in flight.
// ----------------------------------------------------------------------------
module joystick_axis_autocal_mapper_unit #(
  parameter int ADC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [jaam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ADC_BITS-1:0]                 cfg_data,
  // Sample stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata from bit 0: x_sample, y_sample, zero padding
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]     s_tdata,
  // Result stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata from bit 0: x_axis, y_axis, axes_changed, x_min_seen, x_max_seen,
  // y_min_seen, y_max_seen, bounds_changed, zero padding
  output logic [((4*ADC_BITS+2*jaam_pkg::AXIS_W+2+7)/8)*8-1:0] m_tdata
);

  localparam int OUT_W = ((4*ADC_BITS + 2*jaam_pkg::AXIS_W + 2 + 7) / 8) * 8;

  // Configuration registers
  logic [ADC_BITS-1:0] x_center;
  logic [ADC_BITS-1:0] y_center;
  logic                invert_x;
  logic                invert_y;

  jaam_pkg::ctl_state_t state, state_next;

  logic                               start;
  logic                               load;
  logic                               lanes_done;

  logic signed [jaam_pkg::AXIS_W-1:0] x_axis;
  logic signed [jaam_pkg::AXIS_W-1:0] y_axis;
  logic [ADC_BITS-1:0]                x_lo;
  logic [ADC_BITS-1:0]                x_hi;
  logic [ADC_BITS-1:0]                y_lo;
  logic [ADC_BITS-1:0]                y_hi;
  jaam_pkg::lane_stat_t               x_stat;
  jaam_pkg::lane_stat_t               y_stat;

  // Register writes: decode the index, keep the low bits of the data
  always_ff @(posedge clk) begin
    if (rst) begin
      x_center <= ADC_BITS'(jaam_pkg::CENTER_RESET);
      y_center <= ADC_BITS'(jaam_pkg::CENTER_RESET);
      invert_x <= 1'b1;
      invert_y <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        jaam_pkg::CFG_X_CENTER: x_center <= cfg_data;
        jaam_pkg::CFG_Y_CENTER: y_center <= cfg_data;
        jaam_pkg::CFG_INVERT_X: invert_x <= cfg_data[0];
        jaam_pkg::CFG_INVERT_Y: invert_y <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lanes_done = x_stat.done && y_stat.done;

  // Controller: idle, lanes busy, result pending for the output register
  always_comb begin
    state_next = state;
    case (state)
      jaam_pkg::CTL_IDLE: if (s_tvalid) state_next = jaam_pkg::CTL_BUSY;
      jaam_pkg::CTL_BUSY: if (lanes_done) state_next = jaam_pkg::CTL_PEND;
      jaam_pkg::CTL_PEND: if (!m_tvalid || m_tready) state_next = jaam_pkg::CTL_IDLE;
      default:            state_next = jaam_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == jaam_pkg::CTL_IDLE);
    start    = s_tready && s_tvalid;
    // load only once the output register is free or being emptied
    load     = (state == jaam_pkg::CTL_PEND) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jaam_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  jaam_lane #(.ADC_BITS(ADC_BITS)) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (s_tdata[ADC_BITS-1:0]),
    .center (x_center),
    .invert (invert_x),
    .axis   (x_axis),
    .lo     (x_lo),
    .hi     (x_hi),
    .stat   (x_stat)
  );

  jaam_lane #(.ADC_BITS(ADC_BITS)) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .center (y_center),
    .invert (invert_y),
    .axis   (y_axis),
    .lo     (y_lo),
    .hi     (y_hi),
    .stat   (y_stat)
  );

  jaam_merge #(.ADC_BITS(ADC_BITS), .OUT_W(OUT_W)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .x_axis   (x_axis),
    .y_axis   (y_axis),
    .x_lo     (x_lo),
    .x_hi     (x_hi),
    .y_lo     (y_lo),
    .y_hi     (y_hi),
    .x_stat   (x_stat),
    .y_stat   (y_stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/jaam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jaam_checker
// Port-level checks for the joystick axis mapper, bound to the top level.
// ----------------------------------------------------------------------------
module jaam_checker #(
  parameter int ADC_BITS = 12
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((4*ADC_BITS+2*jaam_pkg::AXIS_W+2+7)/8)*8-1:0] m_tdata
);

  localparam int AW   = jaam_pkg::AXIS_W;
  localparam int XMIN = 2*AW + 1;
  localparam int XMAX = XMIN + ADC_BITS;
  localparam int YMIN = XMAX + ADC_BITS;
  localparam int YMAX = YMIN + ADC_BITS;

  // One item in flight: no new sample straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while previous item still in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Tracked bounds stay ordered
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[XMAX-1:XMIN] <= m_tdata[XMAX+ADC_BITS-1:XMAX]) &&
                  (m_tdata[YMAX-1:YMIN] <= m_tdata[YMAX+ADC_BITS-1:YMAX])))
    else $error("tracked low bound above high bound");

  // Mapped axes stay within full scale
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(m_tdata[AW-1:0]) <= 16'sd32760) &&
                  ($signed(m_tdata[AW-1:0]) >= -16'sd32760) &&
                  ($signed(m_tdata[2*AW-1:AW]) <= 16'sd32760) &&
                  ($signed(m_tdata[2*AW-1:AW]) >= -16'sd32760)))
    else $error("mapped axis beyond full scale");

endmodule

bind joystick_axis_autocal_mapper_unit jaam_checker #(.ADC_BITS(ADC_BITS)) u_jaam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
